### sv/stuffed_frame_receiver_crc16_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stuffed frame receiver
// Implication checks on a clock with asynchronous active-low reset; empty
// bodies when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH
`ifndef SYNTH
`define SFR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SFR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SFR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### sv/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Constants, result type and CRC-16 byte update for the stuffed frame receiver.
// ---------------------------------------------------------------------------
package sfr_pkg;

	localparam int SFR_MAX_STUFFED = 512;
	localparam int SFR_MAX_PAYLOAD = 256;

	localparam logic [7:0]  SOF_BYTE = 8'hAA;
	localparam logic [7:0]  ESC_BYTE = 8'h1B;
	localparam logic [7:0]  ESC_FLIP = 8'h20;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_DATA    = 2'd0;
	localparam kind_t KIND_GOOD    = 2'd1;
	localparam kind_t KIND_CRC_ERR = 2'd2;
	localparam kind_t KIND_LEN_ERR = 2'd3;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] type_byte;
		logic [7:0] seq;
		logic [8:0] payload_count;
		logic       last;
	} sfr_result_t;

	function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((x & CRC_TOP) != 16'h0000) begin
				x = {x[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				x = {x[14:0], 1'b0};
			end
		end
		return x;
	endfunction

endpackage

### sv/sfr_byte_if.sv
// ---------------------------------------------------------------------------
// sfr_byte_if
// Received byte channel: valid/ready handshake with one link byte per word.
// ---------------------------------------------------------------------------
interface sfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

### sv/sfr_result_if.sv
// ---------------------------------------------------------------------------
// sfr_result_if
// Result channel: valid/ready handshake carrying payload bytes and frame ends.
// ---------------------------------------------------------------------------
interface sfr_result_if;
	import sfr_pkg::*;

	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] data_byte;
	logic [7:0] type_byte;
	logic [7:0] seq;
	logic [8:0] payload_count;
	logic       last;

	modport source(output valid, output kind, output data_byte, output type_byte,
		output seq, output payload_count, output last, input ready);
	modport sink(input valid, input kind, input data_byte, input type_byte,
		input seq, input payload_count, input last, output ready);
endinterface

### sv/stuffed_frame_receiver_crc16_unit.sv
// ---------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_unit
// Byte-stuffed frame receiver with CRC-16/CCITT-FALSE check.
// ---------------------------------------------------------------------------
// Takes one link byte per cycle. A taken byte sits in an input register, the
// parser and the one-byte CRC update run combinationally on it, and any result
// lands in an output register. Payload bytes stream out as they are unstuffed;
// the frame ends with a good, crc error or length error word, and the sink is
// to drop the frame's payload on error; the block does not enforce this. Input
// stalls only while the result register is full and not being taken.
module stuffed_frame_receiver_crc16_unit #(
	parameter int MAX_STUFFED = sfr_pkg::SFR_MAX_STUFFED,
	parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
	input  logic         clk,
	input  logic         arst_n,
	sfr_byte_if.sink     rx,
	sfr_result_if.source res
);
	import sfr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        free;
	logic        fire;
	sfr_result_t result;

	assign adv = valid_s1 && free;

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfr_deframe #(
		.MAX_STUFFED (MAX_STUFFED),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_deframe (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.fire    (fire),
		.res     (result)
	);

	sfr_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.res    (result),
		.free   (free),
		.out    (res)
	);

endmodule

### sv/sfr_in_stage.sv
// ---------------------------------------------------------------------------
// sfr_in_stage
// Input register: takes one link byte per word and holds it until processed.
// ---------------------------------------------------------------------------
module sfr_in_stage (
	input  logic        clk,
	input  logic        arst_n,
	sfr_byte_if.sink    rx,
	input  logic        adv,
	output logic        valid_s1,
	output logic [7:0]  byte_s1
);
	import sfr_pkg::*;

	logic take;

	assign rx.ready = !valid_s1 || adv;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

### sv/sfr_deframe.sv
// ---------------------------------------------------------------------------
// sfr_deframe
// Frame parser: hunt, header, unstuffing, CRC-16 update and check, one byte
// per cycle while the pipeline advances, with replay of the header after a length error.
// ---------------------------------------------------------------------------
`include "stuffed_frame_receiver_crc16_unit_macros.svh"

module sfr_deframe #(
	parameter int MAX_STUFFED = sfr_pkg::SFR_MAX_STUFFED,
	parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          byte_s1,
	output logic                fire,
	output sfr_pkg::sfr_result_t res
);
	import sfr_pkg::*;

	localparam int LW = $clog2(MAX_STUFFED + 1);
	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_SEQ   = 3'd2;
	localparam logic [2:0] PH_LENLO = 3'd3;
	localparam logic [2:0] PH_LENHI = 3'd4;
	localparam logic [2:0] PH_BODY  = 3'd5;
	localparam logic [2:0] PH_CRCLO = 3'd6;
	localparam logic [2:0] PH_CRCHI = 3'd7;

	logic [2:0]    phase_q, phase_d;
	logic [7:0]    type_q, type_d;
	logic [7:0]    seq_q, seq_d;
	logic [7:0]    lenlo_q, lenlo_d;
	logic [7:0]    crclo_q, crclo_d;
	logic [LW-1:0] rem_q, rem_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_n;
	logic          esc_q, esc_d;
	logic [15:0]   crc_q, crc_d;
	logic [15:0]   alt0_q, alt0_d;
	logic [15:0]   alt1_q, alt1_d;

	logic [15:0]   crc_n, crc_a0, crc_a1, crc_ff, len16;
	logic          len_err, hit, have;
	logic [7:0]    v;
	sfr_result_t   r;

	assign crc_n   = crc_add(crc_q, byte_s1);
	assign crc_a0  = crc_add(alt0_q, byte_s1);
	assign crc_a1  = crc_add(alt1_q, byte_s1);
	assign crc_ff  = crc_add(CRC_INIT, byte_s1);
	assign len16   = {byte_s1, lenlo_q};
	assign len_err = len16 > 16'(MAX_STUFFED);
	assign cnt_n   = cnt_q + CW'(1);

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		seq_d   = seq_q;
		lenlo_d = lenlo_q;
		crclo_d = crclo_q;
		rem_d   = rem_q;
		cnt_d   = cnt_q;
		esc_d   = esc_q;
		crc_d   = crc_q;
		alt0_d  = alt0_q;
		alt1_d  = alt1_q;
		hit     = 1'b0;
		have    = 1'b1;
		v       = byte_s1;
		r           = '0;
		r.type_byte = type_q;
		r.seq       = seq_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == SOF_BYTE) begin
					crc_d   = CRC_INIT;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d  = byte_s1;
				crc_d   = crc_n;
				phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				seq_d   = byte_s1;
				crc_d   = crc_n;
				alt0_d  = crc_ff;
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				lenlo_d = byte_s1;
				crc_d   = crc_n;
				alt0_d  = crc_a0;
				alt1_d  = crc_ff;
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				if (len_err) begin
					hit    = 1'b1;
					r.kind = KIND_LEN_ERR;
					r.last = 1'b1;
					// rescan the stored header for a start byte and resume parsing after it
					if (type_q == SOF_BYTE) begin
						type_d  = seq_q;
						seq_d   = lenlo_q;
						lenlo_d = byte_s1;
						crc_d   = crc_a0;
						alt0_d  = crc_a1;
						alt1_d  = crc_ff;
						phase_d = PH_LENHI;
					end else if (seq_q == SOF_BYTE) begin
						type_d  = lenlo_q;
						seq_d   = byte_s1;
						crc_d   = crc_a1;
						alt0_d  = crc_ff;
						phase_d = PH_LENLO;
					end else if (lenlo_q == SOF_BYTE) begin
						type_d  = byte_s1;
						crc_d   = crc_ff;
						phase_d = PH_SEQ;
					end else if (byte_s1 == SOF_BYTE) begin
						crc_d   = CRC_INIT;
						phase_d = PH_TYPE;
					end else begin
						phase_d = PH_HUNT;
					end
				end else begin
					crc_d   = crc_n;
					rem_d   = len16[LW-1:0];
					cnt_d   = '0;
					esc_d   = 1'b0;
					phase_d = (len16 == 16'h0000) ? PH_CRCLO : PH_BODY;
				end
			end
			PH_BODY: begin
				crc_d = crc_n;
				rem_d = rem_q - LW'(1);
				if (esc_q) begin
					v     = byte_s1 ^ ESC_FLIP;
					esc_d = 1'b0;
				end else if (byte_s1 == ESC_BYTE) begin
					esc_d = 1'b1;
					have  = 1'b0;
				end
				if (have && (cnt_q < CW'(MAX_PAYLOAD))) begin
					cnt_d           = cnt_n;
					hit             = 1'b1;
					r.kind          = KIND_DATA;
					r.data_byte     = v;
					r.payload_count = 9'(cnt_n);
				end
				// drop a trailing escape
				if (rem_q == LW'(1)) begin
					esc_d   = 1'b0;
					phase_d = PH_CRCLO;
				end
			end
			PH_CRCLO: begin
				crclo_d = byte_s1;
				phase_d = PH_CRCHI;
			end
			PH_CRCHI: begin
				hit             = 1'b1;
				r.kind          = ({byte_s1, crclo_q} == crc_q) ? KIND_GOOD : KIND_CRC_ERR;
				r.payload_count = 9'(cnt_q);
				r.last          = 1'b1;
				phase_d         = PH_HUNT;
			end
		endcase
	end

	assign fire = adv && hit;
	assign res  = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			type_q  <= '0;
			seq_q   <= '0;
			lenlo_q <= '0;
			crclo_q <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			esc_q   <= 1'b0;
			crc_q   <= CRC_INIT;
			alt0_q  <= CRC_INIT;
			alt1_q  <= CRC_INIT;
		end else if (adv) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			seq_q   <= seq_d;
			lenlo_q <= lenlo_d;
			crclo_q <= crclo_d;
			rem_q   <= rem_d;
			cnt_q   <= cnt_d;
			esc_q   <= esc_d;
			crc_q   <= crc_d;
			alt0_q  <= alt0_d;
			alt1_q  <= alt1_d;
		end
	end

	`SFR_ASSERT_NEXT(a_end_leaves_frame, clk, arst_n, fire && r.last, (phase_q != PH_BODY) && (phase_q != PH_CRCLO) && (phase_q != PH_CRCHI))
	`SFR_ASSERT_IMP(a_data_in_body, clk, arst_n, fire && (r.kind == KIND_DATA), phase_q == PH_BODY)
	`SFR_ASSERT_NEXT(a_count_steps, clk, arst_n, fire && (r.kind == KIND_DATA), cnt_q == $past(cnt_q) + CW'(1))
	`SFR_ASSERT_IMP(a_body_has_bytes, clk, arst_n, phase_q == PH_BODY, rem_q != '0)
	`SFR_ASSERT_IMP(a_count_capped, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_PAYLOAD))

endmodule

### sv/sfr_out_stage.sv
// ---------------------------------------------------------------------------
// sfr_out_stage
// Result register: holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module sfr_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  sfr_pkg::sfr_result_t res,
	output logic                free,
	sfr_result_if.source        out
);
	import sfr_pkg::*;

	logic        res_valid_q;
	sfr_result_t res_q;

	assign free = !res_valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out.valid         = res_valid_q;
	assign out.kind          = res_q.kind;
	assign out.data_byte     = res_q.data_byte;
	assign out.type_byte     = res_q.type_byte;
	assign out.seq           = res_q.seq;
	assign out.payload_count = res_q.payload_count;
	assign out.last          = res_q.last;

endmodule
